// ===== rtl/slm_pkg.sv =====
// Shared types and constants for the sorted list merge block.
`timescale 1ns / 1ps

package slm_pkg;

	// Field widths of the input and result words.
	localparam int CMD_W = 2;
	localparam int VAL_W = 32;

	// Default list depth.
	localparam int LIST_DEPTH_DEF = 32;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_PUSH_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;

	// Control flags from the sequencer to the datapath.
	typedef struct packed {
		logic req_ready;
		logic wr_a;
		logic wr_b;
		logic a_has;
		logic b_has;
		logic load;
		logic last;
		logic empty;
		logic ovf;
	} slm_ctrl_t;

endpackage

// ===== rtl/slm_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps

interface slm_in_if;
	logic                            valid;
	logic                            ready;
	logic [slm_pkg::CMD_W-1:0]       cmd;
	logic signed [slm_pkg::VAL_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface slm_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [slm_pkg::VAL_W-1:0] merged_value;
	logic                            last;
	logic                            empty_res;
	logic                            overflow;

	modport source (output valid, output merged_value, output last, output empty_res,
		output overflow, input ready);
	modport sink   (input valid, input merged_value, input last, input empty_res,
		input overflow, output ready);
endinterface

// ===== rtl/slm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module slm_ram #(
	parameter int Width = 32,
	parameter int Depth = 32,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/slm_cmp.sv =====
// Shared compare and select unit that picks the next merged value.
`timescale 1ns / 1ps

module slm_cmp (
	input  logic [slm_pkg::VAL_W-1:0] head_a,
	input  logic [slm_pkg::VAL_W-1:0] head_b,
	input  logic                      a_has,
	input  logic                      b_has,
	output logic                      take_a,
	output logic [slm_pkg::VAL_W-1:0] value
);

	// A goes first only when it is strictly less; ties go to B.
	always_comb begin
		take_a = a_has && (!b_has || ($signed(head_a) < $signed(head_b)));
		value  = take_a ? head_a : head_b;
	end

endmodule

// ===== rtl/slm_seq.sv =====
// Sequencer: list fill counts, merge indexes, overflow flag and merge steps.
`timescale 1ns / 1ps

module slm_seq #(
	parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF,
	localparam int AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_fire,
	input  logic [slm_pkg::CMD_W-1:0] cmd,
	input  logic                      out_free,
	input  logic                      take_a,
	output logic [AddrW-1:0]          wr_addr_a,
	output logic [AddrW-1:0]          wr_addr_b,
	output logic [AddrW-1:0]          rd_addr_a,
	output logic [AddrW-1:0]          rd_addr_b,
	output slm_pkg::slm_ctrl_t        ctrl
);

	localparam int CntW = $clog2(LIST_DEPTH + 1);
	localparam logic [CntW-1:0] Full = CntW'(LIST_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_PICK  = 4'b0100,
		S_EMPTY = 4'b1000
	} state_t;

	state_t          state_q, state_d;
	logic [CntW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
	logic [CntW-1:0] ia_q, ia_d, ib_q, ib_d;
	logic            ovf_q, ovf_d;
	logic [CntW-1:0] ia_nxt, ib_nxt;
	logic            push_a, push_b, do_merge;

	assign wr_addr_a = cnt_a_q[AddrW-1:0];
	assign wr_addr_b = cnt_b_q[AddrW-1:0];
	assign rd_addr_a = ia_q[AddrW-1:0];
	assign rd_addr_b = ib_q[AddrW-1:0];

	assign push_a   = req_fire && (cmd == slm_pkg::CMD_PUSH_A);
	assign push_b   = req_fire && (cmd == slm_pkg::CMD_PUSH_B);
	assign do_merge = req_fire && (cmd == slm_pkg::CMD_MERGE);

	// Indexes after the current pick.
	assign ia_nxt = ia_q + CntW'(take_a);
	assign ib_nxt = ib_q + CntW'(!take_a);

	// Next-state and control logic.
	always_comb begin
		state_d = state_q;
		cnt_a_d = cnt_a_q;
		cnt_b_d = cnt_b_q;
		ia_d    = ia_q;
		ib_d    = ib_q;
		ovf_d   = ovf_q;

		ctrl           = '0;
		ctrl.req_ready = (state_q == S_IDLE);
		ctrl.a_has     = (ia_q < cnt_a_q);
		ctrl.b_has     = (ib_q < cnt_b_q);
		ctrl.ovf       = ovf_q;

		case (state_q)
			S_IDLE: begin
				// Pushes append at the fill count; a full list drops the word.
				if (push_a) begin
					if (cnt_a_q == Full) begin
						ovf_d = 1'b1;
					end else begin
						ctrl.wr_a = 1'b1;
						cnt_a_d   = cnt_a_q + CntW'(1);
					end
				end
				if (push_b) begin
					if (cnt_b_q == Full) begin
						ovf_d = 1'b1;
					end else begin
						ctrl.wr_b = 1'b1;
						cnt_b_d   = cnt_b_q + CntW'(1);
					end
				end
				if (do_merge) begin
					ia_d = '0;
					ib_d = '0;
					if ((cnt_a_q == '0) && (cnt_b_q == '0)) begin
						state_d = S_EMPTY;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				// Heads are addressed; read data arrives next cycle.
				state_d = S_PICK;
			end
			S_PICK: begin
				if (out_free) begin
					ctrl.load = 1'b1;
					ctrl.last = (ia_nxt == cnt_a_q) && (ib_nxt == cnt_b_q);
					if (ctrl.last) begin
						cnt_a_d = '0;
						cnt_b_d = '0;
						ia_d    = '0;
						ib_d    = '0;
						ovf_d   = 1'b0;
						state_d = S_IDLE;
					end else begin
						ia_d    = ia_nxt;
						ib_d    = ib_nxt;
						state_d = S_READ;
					end
				end
			end
			S_EMPTY: begin
				if (out_free) begin
					ctrl.load  = 1'b1;
					ctrl.last  = 1'b1;
					ctrl.empty = 1'b1;
					ovf_d      = 1'b0;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ia_q    <= '0;
			ib_q    <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_a_q <= cnt_a_d;
			cnt_b_q <= cnt_b_d;
			ia_q    <= ia_d;
			ib_q    <= ib_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

// ===== rtl/sorted_list_merge.sv =====
// Sorted list merge top level: two list RAMs, compare unit, sequencer, result register.
// A push word is taken while the block is idle, and the block stays ready for the next word.
// A merge of N stored words gives N results, each from a RAM read state, then a compare
// and load of the result register; the result side can stall the load.
// A merge of two empty lists gives one flagged result, with the empty and last flags set.
// Reset clears the fill counts, the overflow flag and the result valid; RAM data is not reset.
`timescale 1ns / 1ps

module sorted_list_merge #(
	parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	slm_in_if.sink     req,
	slm_out_if.source  rsp
);

	localparam int AddrW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	slm_pkg::slm_ctrl_t              ctrl;
	logic [AddrW-1:0]                wr_addr_a, wr_addr_b, rd_addr_a, rd_addr_b;
	logic [slm_pkg::VAL_W-1:0]       head_a, head_b, pick_value;
	logic                            take_a, out_free, req_fire;
	logic                            valid_q;
	logic [slm_pkg::VAL_W-1:0]       value_q;
	logic                            last_q, empty_q, ovf_q;

	assign req.ready = ctrl.req_ready;
	assign req_fire  = req.valid && ctrl.req_ready;
	assign out_free  = !valid_q || rsp.ready;

	slm_seq #(.LIST_DEPTH(LIST_DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_fire  (req_fire),
		.cmd       (req.cmd),
		.out_free  (out_free),
		.take_a    (take_a),
		.wr_addr_a (wr_addr_a),
		.wr_addr_b (wr_addr_b),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.ctrl      (ctrl)
	);

	slm_ram #(.Width(slm_pkg::VAL_W), .Depth(LIST_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (ctrl.wr_a),
		.waddr (wr_addr_a),
		.wdata (req.value),
		.raddr (rd_addr_a),
		.rdata (head_a)
	);

	slm_ram #(.Width(slm_pkg::VAL_W), .Depth(LIST_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (ctrl.wr_b),
		.waddr (wr_addr_b),
		.wdata (req.value),
		.raddr (rd_addr_b),
		.rdata (head_b)
	);

	slm_cmp u_cmp (
		.head_a (head_a),
		.head_b (head_b),
		.a_has  (ctrl.a_has),
		.b_has  (ctrl.b_has),
		.take_a (take_a),
		.value  (pick_value)
	);

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload; an empty merge reports a zero value.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= ctrl.empty ? '0 : pick_value;
			last_q  <= ctrl.last;
			empty_q <= ctrl.empty;
			ovf_q   <= ctrl.ovf;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.merged_value = value_q;
	assign rsp.last         = last_q;
	assign rsp.empty_res    = empty_q;
	assign rsp.overflow     = ovf_q;

endmodule

// ===== rtl/sorted_list_merge_chk.sv =====
// Port-level checker for the sorted list merge block and its bind statement.
`timescale 1ns / 1ps

module sorted_list_merge_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic [slm_pkg::CMD_W-1:0] req_cmd,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic                      rsp_last,
	input logic                      rsp_empty,
	input logic                      rsp_overflow
);

	// A result word waits until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result word dropped before it was taken");

	// An empty-list result is always the only, and so the last, word.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_empty) |-> rsp_last)
		else $error("empty result without last");

	// A merge occupies the block, so no word is taken in the next cycle.
	a_merge_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && (req_cmd == slm_pkg::CMD_MERGE)) |=> !req_ready)
		else $error("ready right after a merge was taken");

	// The overflow flag is constant across the words of one merge.
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready && !rsp_last) |=>
		(!rsp_valid || (rsp_overflow == $past(rsp_overflow))))
		else $error("overflow flag changed within a merge");

endmodule

bind sorted_list_merge sorted_list_merge_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_cmd      (req.cmd),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_last     (rsp.last),
	.rsp_empty    (rsp.empty_res),
	.rsp_overflow (rsp.overflow)
);

// ===== bench/sorted_list_merge_test.sv =====
// Self-checking testbench for the sorted list merge block.
`timescale 1ns / 1ps

module sorted_list_merge_test;

	// The fourth command code is unused and must be ignored by the block.
	localparam logic [slm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int WORD_TARGET = 430;
	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT = 37;
	localparam int MAX_REPORTS = 10;

	// One expected result word of a merge.
	typedef struct {
		logic signed [slm_pkg::VAL_W-1:0] merged_value;
		logic                             last;
		logic                             empty_res;
		logic                             overflow;
	} merge_word_t;

	// Tracks both lists and queues the merge output they should produce.
	class merge_scoreboard;
		logic signed [slm_pkg::VAL_W-1:0] list_a[$];
		logic signed [slm_pkg::VAL_W-1:0] list_b[$];
		bit                               dropped_push;
		merge_word_t                      due_words[$];
		int                               mismatches;

		function int pending();
			return due_words.size();
		endfunction

		function void add_word(logic signed [slm_pkg::VAL_W-1:0] v, bit is_last,
			bit is_empty);
			merge_word_t w;
			w.merged_value = v;
			w.last = is_last;
			w.empty_res = is_empty;
			w.overflow = dropped_push;
			due_words.push_back(w);
		endfunction

		// Apply one accepted input word to the list state.
		function void note_word(logic [slm_pkg::CMD_W-1:0] cmd,
			logic signed [slm_pkg::VAL_W-1:0] value);
			int ia;
			int ib;
			int total;
			logic signed [slm_pkg::VAL_W-1:0] v;
			ia = 0;
			ib = 0;
			case (cmd)
				slm_pkg::CMD_PUSH_A: begin
					if (list_a.size() >= slm_pkg::LIST_DEPTH_DEF) dropped_push = 1'b1;
					else list_a.push_back(value);
				end
				slm_pkg::CMD_PUSH_B: begin
					if (list_b.size() >= slm_pkg::LIST_DEPTH_DEF) dropped_push = 1'b1;
					else list_b.push_back(value);
				end
				slm_pkg::CMD_MERGE: begin
					total = list_a.size() + list_b.size();
					if (total == 0) begin
						add_word('0, 1'b1, 1'b1);
					end else begin
						// A's head leads only when strictly smaller; ties favor B.
						while (ia < list_a.size() || ib < list_b.size()) begin
							if (ia < list_a.size() && ib < list_b.size()) begin
								if (list_a[ia] < list_b[ib]) begin
									v = list_a[ia];
									ia++;
								end else begin
									v = list_b[ib];
									ib++;
								end
							end else if (ia < list_a.size()) begin
								v = list_a[ia];
								ia++;
							end else begin
								v = list_b[ib];
								ib++;
							end
							add_word(v, (ia + ib) == total, 1'b0);
						end
					end
					list_a.delete();
					list_b.delete();
					dropped_push = 1'b0;
				end
				default: begin
				end
			endcase
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS) $display("%s", msg);
		endfunction

		// Compare one accepted result word with the oldest expectation.
		function void check_result(logic signed [slm_pkg::VAL_W-1:0] value, logic last,
			logic empty_res, logic overflow);
			merge_word_t w;
			if (due_words.size() == 0) begin
				report($sformatf("unexpected result: value %0d last %b empty %b ovf %b",
					value, last, empty_res, overflow));
				return;
			end
			w = due_words.pop_front();
			// An empty merge reports a zero value.
			if (last !== w.last || empty_res !== w.empty_res || overflow !== w.overflow ||
				value !== w.merged_value) begin
				report($sformatf({"result mismatch: expected value %0d last %b empty %b ",
					"ovf %b, got value %0d last %b empty %b ovf %b"},
					w.merged_value, w.last, w.empty_res, w.overflow,
					value, last, empty_res, overflow));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   words_sent;
	int   cycle_count;

	slm_in_if  req_ch();
	slm_out_if rsp_ch();

	merge_scoreboard sb = new();

	sorted_list_merge uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Free-running clock, 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_list_merge_test failed");
			$finish;
		end
	end

	// Result side: check each accepted word and stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.merged_value, rsp_ch.last, rsp_ch.empty_res,
					rsp_ch.overflow);
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Offer one word, with a random gap first, and wait for its acceptance.
	task automatic send_word(input logic [slm_pkg::CMD_W-1:0] cmd,
		input logic signed [slm_pkg::VAL_W-1:0] value);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.value <= value;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_word(cmd, value);
		if (cmd != CMD_UNUSED) words_sent++;
	endtask

	// Hold the input side until every expected result has come back.
	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic signed [slm_pkg::VAL_W-1:0] pick_value(bit narrow);
		if (narrow) return $signed(32'($urandom_range(0, 15))) - 8;
		return $urandom;
	endfunction

	// Fill both lists, interleaving the pushes at random, then merge.
	task automatic merge_set(input int n_a, input int n_b, input bit narrow,
		input bit ordered, input bit noisy);
		logic signed [slm_pkg::VAL_W-1:0] qa[$];
		logic signed [slm_pkg::VAL_W-1:0] qb[$];
		repeat (n_a) qa.push_back(pick_value(narrow));
		repeat (n_b) qb.push_back(pick_value(narrow));
		if (ordered) begin
			qa.sort();
			qb.sort();
		end
		while (qa.size() != 0 || qb.size() != 0) begin
			if (noisy && $urandom_range(0, 9) == 0) send_word(CMD_UNUSED, $urandom);
			if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 0))
				send_word(slm_pkg::CMD_PUSH_A, qa.pop_front());
			else
				send_word(slm_pkg::CMD_PUSH_B, qb.pop_front());
		end
		send_word(slm_pkg::CMD_MERGE, $urandom);
	endtask

	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return slm_pkg::LIST_DEPTH_DEF + $urandom_range(0, 3);
		if (r < 12) return 0;
		return $urandom_range(1, 8);
	endfunction

	// Stimulus: reset, directed cases, then random list sets.
	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		words_sent = 0;
		cycle_count = 0;
		req_ch.valid = 1'b0;
		req_ch.cmd = slm_pkg::CMD_PUSH_A;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes on both lists, equal heads, and an ignored command mid-fill.
		send_word(slm_pkg::CMD_PUSH_A, 32'sh8000_0000);
		send_word(slm_pkg::CMD_PUSH_B, 32'sh8000_0000);
		send_word(slm_pkg::CMD_PUSH_A, -1);
		send_word(slm_pkg::CMD_PUSH_B, 5);
		send_word(CMD_UNUSED, 32'shFFFF_FFFF);
		send_word(slm_pkg::CMD_PUSH_A, 5);
		send_word(slm_pkg::CMD_PUSH_A, 32'sh7FFF_FFFF);
		send_word(slm_pkg::CMD_PUSH_B, 32'sh7FFF_FFFF);
		send_word(slm_pkg::CMD_MERGE, 32'sh7FFF_FFFF);
		// Merge of two empty lists.
		send_word(slm_pkg::CMD_MERGE, 0);
		// Only list B holds values.
		send_word(slm_pkg::CMD_PUSH_B, 0);
		send_word(slm_pkg::CMD_PUSH_B, 1);
		send_word(slm_pkg::CMD_MERGE, 0);
		// Only list A holds values.
		send_word(slm_pkg::CMD_PUSH_A, 32'sh5555_5555);
		send_word(slm_pkg::CMD_PUSH_A, 32'sh7FFF_0000);
		send_word(slm_pkg::CMD_MERGE, -1);
		// An ignored command alone must leave both lists empty.
		send_word(CMD_UNUSED, 0);
		send_word(slm_pkg::CMD_MERGE, 0);
		wait_for_results();

		// Random sets: mostly sorted lists, some ties, some unsorted or noisy fills.
		while (words_sent < WORD_TARGET) begin
			calm = (words_sent >= 200 && words_sent < 280);
			merge_set(pick_size(), pick_size(), $urandom_range(0, 3) == 0,
				$urandom_range(0, 9) != 0, $urandom_range(0, 4) == 0);
			if ($urandom_range(0, 7) == 0) wait_for_results();
		end
		calm = 1'b0;

		wait_for_results();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("sorted_list_merge_test passed");
		else
			$display("sorted_list_merge_test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/slm_pkg.sv
rtl/slm_if.sv
rtl/slm_ram.sv
rtl/slm_cmp.sv
rtl/slm_seq.sv
rtl/sorted_list_merge.sv
rtl/sorted_list_merge_chk.sv
bench/sorted_list_merge_test.sv
